[sv/swept_aabb_entry_time_defines.svh]
// assertion macros for the swept box entry time block
// used by sv/sat_contact.sv, expects clk and rst in scope
`ifndef SWEPT_AABB_ENTRY_TIME_DEFINES_SVH
`define SWEPT_AABB_ENTRY_TIME_DEFINES_SVH
`ifndef SYNTH
`define SAT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sat same-cycle check failed");
`define SAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sat next-cycle check failed");
`else
`define SAT_ASSERT_SAME(lbl, ante, cons)
`define SAT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/sat_pkg.sv]
// shared types and constants for the swept box entry time block
// no dependencies
package sat_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ENTRY_W = 17;
  localparam int WIDE_W = 41;

  typedef struct packed {
    logic signed [31:0] wl;
    logic signed [31:0] wr;
    logic signed [31:0] wb;
    logic signed [31:0] wt;
    logic signed [31:0] ml;
    logic signed [31:0] mr;
    logic signed [31:0] mb;
    logic signed [31:0] mt;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } sat_box_t;

  typedef struct packed {
    logic        cand;
    logic [32:0] rem;
    logic [31:0] den;
  } sat_axis_t;

endpackage

[sv/sat_setup.sv]
// first stage: edge crossing tests, gap and speed magnitudes per axis
// depends on sat_pkg
module sat_setup (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_i,
  input  sat_pkg::sat_box_t box_i,
  output logic              valid_o,
  output sat_pkg::sat_box_t box_o,
  output sat_pkg::sat_axis_t ax_o,
  output sat_pkg::sat_axis_t ay_o
);
  import sat_pkg::*;

  function automatic sat_axis_t axis_setup(input logic signed [31:0] lo,
                                           input logic signed [31:0] hi,
                                           input logic signed [31:0] wlo,
                                           input logic signed [31:0] whi,
                                           input logic signed [31:0] v);
    sat_axis_t a;
    logic signed [32:0] lo_w, hi_w, wlo_w, whi_w, v_w, gap;
    lo_w = 33'(lo);
    hi_w = 33'(hi);
    wlo_w = 33'(wlo);
    whi_w = 33'(whi);
    v_w = 33'(v);
    a.cand = 1'b0;
    a.rem = '0;
    a.den = '0;
    if (!v[31] && v != 32'sd0) begin
      a.cand = (hi_w <= wlo_w) && (34'(hi_w) + 34'(v_w) > 34'(wlo_w));
      gap = wlo_w - hi_w;
      a.rem = gap;
      a.den = v;
    end else if (v[31]) begin
      a.cand = (lo_w >= whi_w) && (34'(lo_w) + 34'(v_w) < 34'(whi_w));
      gap = lo_w - whi_w;
      a.rem = gap;
      a.den = 32'(-v_w);
    end
    return a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_o <= box_i;
      ax_o <= axis_setup(box_i.ml, box_i.mr, box_i.wl, box_i.wr, box_i.vx);
      ay_o <= axis_setup(box_i.mb, box_i.mt, box_i.wb, box_i.wt, box_i.vy);
    end
  end

endmodule

[sv/sat_div_stage.sv]
// one restoring division step per axis, one quotient bit a stage
// depends on sat_pkg
module sat_div_stage #(
  parameter int FRAC_BITS = sat_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_i,
  input  sat_pkg::sat_box_t    box_i,
  input  sat_pkg::sat_axis_t   ax_i,
  input  sat_pkg::sat_axis_t   ay_i,
  input  logic [FRAC_BITS-1:0] qx_i,
  input  logic [FRAC_BITS-1:0] qy_i,
  output logic                 valid_o,
  output sat_pkg::sat_box_t    box_o,
  output sat_pkg::sat_axis_t   ax_o,
  output sat_pkg::sat_axis_t   ay_o,
  output logic [FRAC_BITS-1:0] qx_o,
  output logic [FRAC_BITS-1:0] qy_o
);
  import sat_pkg::*;

  logic [32:0] rx2, ry2;
  logic gex, gey;

  always_comb begin
    rx2 = {ax_i.rem[31:0], 1'b0};
    ry2 = {ay_i.rem[31:0], 1'b0};
    gex = rx2 >= {1'b0, ax_i.den};
    gey = ry2 >= {1'b0, ay_i.den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_o <= box_i;
      ax_o.cand <= ax_i.cand;
      ax_o.den <= ax_i.den;
      ax_o.rem <= gex ? rx2 - {1'b0, ax_i.den} : rx2;
      ay_o.cand <= ay_i.cand;
      ay_o.den <= ay_i.den;
      ay_o.rem <= gey ? ry2 - {1'b0, ay_i.den} : ry2;
      qx_o <= {qx_i[FRAC_BITS-2:0], gex};
      qy_o <= {qy_i[FRAC_BITS-2:0], gey};
    end
  end

endmodule

[sv/sat_contact.sv]
// other-axis shift by velocity times entry time, overlap test, result register
// depends on sat_pkg and swept_aabb_entry_time_defines.svh
`include "swept_aabb_entry_time_defines.svh"
module sat_contact #(
  parameter int FRAC_BITS = sat_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid_i,
  input  sat_pkg::sat_box_t            box_i,
  input  logic                         cand_x_i,
  input  logic                         cand_y_i,
  input  logic [FRAC_BITS-1:0]         qx_i,
  input  logic [FRAC_BITS-1:0]         qy_i,
  output logic                         valid_o,
  output logic                         hit,
  output logic [sat_pkg::ENTRY_W-1:0]  entry_x,
  output logic [sat_pkg::ENTRY_W-1:0]  entry_y
);
  import sat_pkg::*;

  localparam int PW = 32 + FRAC_BITS + 1;
  localparam logic [WIDE_W-1:0] ONE_W = WIDE_W'(1) << FRAC_BITS;
  localparam logic [ENTRY_W-1:0] ONE_E = ONE_W[ENTRY_W-1:0];

  logic                  valid_a;
  sat_box_t              box_a;
  logic                  cand_x_a, cand_y_a;
  logic [FRAC_BITS-1:0]  qx_a, qy_a;
  logic signed [PW-1:0]  px_a, py_a;

  logic signed [PW-1:0]  shx_w, shy_w;
  logic signed [34:0]    shx, shy;
  logic                  hx, hy;
  logic [WIDE_W-1:0]     qx_w, qy_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_a <= box_i;
      cand_x_a <= cand_x_i;
      cand_y_a <= cand_y_i;
      qx_a <= qx_i;
      qy_a <= qy_i;
      px_a <= PW'(box_i.vy) * $signed({1'b0, qx_i});
      py_a <= PW'(box_i.vx) * $signed({1'b0, qy_i});
    end
  end

  always_comb begin
    shx_w = px_a >>> FRAC_BITS;
    shy_w = py_a >>> FRAC_BITS;
    shx = shx_w[34:0];
    shy = shy_w[34:0];
    hx = cand_x_a && (35'(box_a.mb) + shx <= 35'(box_a.wt))
                  && (35'(box_a.mt) + shx >= 35'(box_a.wb));
    hy = cand_y_a && (35'(box_a.ml) + shy <= 35'(box_a.wr))
                  && (35'(box_a.mr) + shy >= 35'(box_a.wl));
    qx_w = WIDE_W'(qx_a);
    qy_w = WIDE_W'(qy_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hx || hy;
      entry_x <= hx ? qx_w[ENTRY_W-1:0] : ONE_E;
      entry_y <= hy ? qy_w[ENTRY_W-1:0] : ONE_E;
    end
  end

  `SAT_ASSERT_NEXT(a_no_x_default, en && !cand_x_a, entry_x == ONE_E)
  `SAT_ASSERT_NEXT(a_no_y_default, en && !cand_y_a, entry_y == ONE_E)
  `SAT_ASSERT_NEXT(a_hit_needs_cand, en && !cand_x_a && !cand_y_a, !hit)
  `SAT_ASSERT_NEXT(a_hold_on_stall, !en, $stable(hit) && $stable(entry_x))

endmodule

[sv/swept_aabb_entry_time.sv]
// swept box entry time: top level, setup stage, division chain, contact stage
// depends on sat_pkg, sat_setup, sat_div_stage, sat_contact
//
// usage
//   src channel (src_valid, src_stall) carries one box pair and velocity per
//   transfer; res channel (res_valid, res_stall) carries hit, entry_x, entry_y.
//   one result per accepted item, in order.
// pipeline from transfer in to res_valid:
//   one setup stage, one stage per quotient bit of the entry time division,
//   one multiply stage and the output register.
// throughput: one item per cycle while not stalled; the divider is fully unrolled into stages.
// stall: while res_valid and res_stall are both high the whole pipeline holds
//   and src_stall is raised; nothing is dropped or repeated.
// reset: rst clears every stage valid bit; res_valid is low after reset.
module swept_aabb_entry_time #(
  parameter int FRAC_BITS = sat_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  logic signed [31:0]          wall_left,
  input  logic signed [31:0]          wall_right,
  input  logic signed [31:0]          wall_bottom,
  input  logic signed [31:0]          wall_top,
  input  logic signed [31:0]          mover_left,
  input  logic signed [31:0]          mover_right,
  input  logic signed [31:0]          mover_bottom,
  input  logic signed [31:0]          mover_top,
  input  logic signed [31:0]          vel_x,
  input  logic signed [31:0]          vel_y,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        hit,
  output logic [sat_pkg::ENTRY_W-1:0] entry_x,
  output logic [sat_pkg::ENTRY_W-1:0] entry_y
);
  import sat_pkg::*;

  logic                 en;
  sat_box_t             box_in;
  logic                 vld_s [0:FRAC_BITS];
  sat_box_t             box_s [0:FRAC_BITS];
  sat_axis_t            ax_s  [0:FRAC_BITS];
  sat_axis_t            ay_s  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] qx_s  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] qy_s  [0:FRAC_BITS];

  assign en = !(res_valid && res_stall);
  assign src_stall = !en;

  always_comb begin
    box_in.wl = wall_left;
    box_in.wr = wall_right;
    box_in.wb = wall_bottom;
    box_in.wt = wall_top;
    box_in.ml = mover_left;
    box_in.mr = mover_right;
    box_in.mb = mover_bottom;
    box_in.mt = mover_top;
    box_in.vx = vel_x;
    box_in.vy = vel_y;
  end

  sat_setup u_setup (
    .clk(clk), .rst(rst), .en(en),
    .valid_i(src_valid), .box_i(box_in),
    .valid_o(vld_s[0]), .box_o(box_s[0]), .ax_o(ax_s[0]), .ay_o(ay_s[0])
  );

  assign qx_s[0] = '0;
  assign qy_s[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    sat_div_stage #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .rst(rst), .en(en),
      .valid_i(vld_s[i]), .box_i(box_s[i]), .ax_i(ax_s[i]), .ay_i(ay_s[i]),
      .qx_i(qx_s[i]), .qy_i(qy_s[i]),
      .valid_o(vld_s[i+1]), .box_o(box_s[i+1]), .ax_o(ax_s[i+1]), .ay_o(ay_s[i+1]),
      .qx_o(qx_s[i+1]), .qy_o(qy_s[i+1])
    );
  end

  sat_contact #(.FRAC_BITS(FRAC_BITS)) u_contact (
    .clk(clk), .rst(rst), .en(en),
    .valid_i(vld_s[FRAC_BITS]), .box_i(box_s[FRAC_BITS]),
    .cand_x_i(ax_s[FRAC_BITS].cand), .cand_y_i(ay_s[FRAC_BITS].cand),
    .qx_i(qx_s[FRAC_BITS]), .qy_i(qy_s[FRAC_BITS]),
    .valid_o(res_valid), .hit(hit), .entry_x(entry_x), .entry_y(entry_y)
  );

endmodule
